// ===== rtl/els_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_pkg
// Shared widths, register indexes, beat and result types of the edge label
// synopsis block.
// ----------------------------------------------------------------------------
package els_pkg;

    localparam int LABEL_W         = 11;
    localparam int NP_W            = 11;
    localparam int GSZ_W           = 12;
    localparam int RES_W           = 12;
    localparam int SYN_COUNT       = 8;
    localparam int LABEL_SPACE_DEF = 2048;
    localparam int EPOCH_W         = 8;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_PRED   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_MODE = 1'b1;

    localparam int SYN_IN_MAX_GROUP  = 0;
    localparam int SYN_IN_DISTINCT   = 1;
    localparam int SYN_IN_MAX_LABEL  = 2;
    localparam int SYN_IN_MIN_LABEL  = 3;
    localparam int SYN_OUT_DISTINCT  = 4;
    localparam int SYN_OUT_MAX_LABEL = 5;
    localparam int SYN_OUT_MIN_LABEL = 6;
    localparam int SYN_OUT_MAX_GROUP = 7;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               group_end;
        logic               signature_end;
        logic               no_label;
    } lbl_item_t;

    typedef struct packed {
        logic fire;
        logic mark;
        logic sig_end;
    } seen_upd_t;

    typedef logic [SYN_COUNT-1:0][RES_W-1:0] syn_vec_t;

endpackage

// ===== rtl/els_seen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_seen
// Seen-label bitmap held as an epoch-tagged memory: one read per accepted
// beat, at most one write per retired beat, write-to-read forwarding,
// and a clearing sweep after reset and on epoch wrap.
// ----------------------------------------------------------------------------
module els_seen import els_pkg::*; #(
    parameter int LABEL_SPACE = LABEL_SPACE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [LABEL_W-1:0] rd_label,
    input  seen_upd_t          upd,
    output logic               seen,
    output logic               busy,
    output logic               last_epoch
);

    localparam int IDX_W = (LABEL_SPACE > 1) ? $clog2(LABEL_SPACE) : 1;

    function automatic logic [IDX_W-1:0] lbl_index(input logic [LABEL_W-1:0] lbl);
        int v;
        v = int'(lbl);
        for (int k = LABEL_W - 1; k >= 0; k--) begin
            if (((LABEL_SPACE << k) < (1 << LABEL_W)) && (v >= (LABEL_SPACE << k))) begin
                v = v - (LABEL_SPACE << k);
            end
        end
        return IDX_W'(v);
    endfunction

    logic [EPOCH_W-1:0] mem [LABEL_SPACE];

    logic [EPOCH_W-1:0] rd_tag_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               fwd_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic               clr_reg;
    logic               clr_next;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [IDX_W-1:0]   clr_addr_next;
    logic [IDX_W-1:0]   rd_idx;
    logic               wr_en;

    assign rd_idx     = lbl_index(rd_label);
    assign wr_en      = upd.fire && upd.mark;
    assign seen       = (rd_tag_reg == epoch_reg) || fwd_reg;
    assign busy       = clr_reg;
    assign last_epoch = (epoch_reg == {EPOCH_W{1'b1}});

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[idx_reg] <= epoch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_tag_reg <= mem[rd_idx];
            idx_reg    <= rd_idx;
        end
    end

    always_comb begin
        epoch_next    = epoch_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(LABEL_SPACE - 1)) begin
                clr_next      = 1'b0;
                clr_addr_next = '0;
            end
        end else if (upd.fire && upd.sig_end) begin
            if (last_epoch) begin
                epoch_next = EPOCH_W'(1);
                clr_next   = 1'b1;
            end else begin
                epoch_next = epoch_reg + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg    <= EPOCH_W'(1);
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            fwd_reg      <= 1'b0;
        end else begin
            epoch_reg    <= epoch_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            if (rd_en) begin
                fwd_reg <= wr_en && !upd.sig_end && (idx_reg == rd_idx);
            end
        end
    end

endmodule

// ===== rtl/els_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_stats
// Per-class accumulators (distinct count, label range, largest group) and
// the synopsis values formed at the end of a signature.
// ----------------------------------------------------------------------------
module els_stats import els_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  lbl_item_t       item,
    input  logic            seen,
    input  logic [NP_W-1:0] num_pred,
    input  logic            query_mode,
    output syn_vec_t        res
);

    logic [GSZ_W-1:0]   in_count_reg,  in_count_next,  in_count_a;
    logic [GSZ_W-1:0]   out_count_reg, out_count_next, out_count_a;
    logic [LABEL_W-1:0] in_low_reg,    in_low_next,    in_low_a;
    logic [LABEL_W-1:0] in_high_reg,   in_high_next,   in_high_a;
    logic [LABEL_W-1:0] out_low_reg,   out_low_next,   out_low_a;
    logic [LABEL_W-1:0] out_high_reg,  out_high_next,  out_high_a;
    logic [GSZ_W-1:0]   gsize_reg,     gsize_next,     gsize_a;
    logic               gis_in_reg,    gis_in_next,    gis_in_a;
    logic [GSZ_W-1:0]   in_gmax_reg,   in_gmax_next,   in_gmax_b;
    logic [GSZ_W-1:0]   out_gmax_reg,  out_gmax_next,  out_gmax_b;

    logic               has;
    logic               is_in;
    logic               close;
    logic [RES_W:0]     inc;
    logic [RES_W:0]     r [SYN_COUNT];

    function automatic logic [RES_W-1:0] sat(input logic [RES_W:0] v);
        return v[RES_W] ? {RES_W{1'b1}} : v[RES_W-1:0];
    endfunction

    assign has   = !item.no_label;
    assign is_in = query_mode ? (item.label <= num_pred) : (item.label < num_pred);
    assign close = (has && item.group_end) || item.signature_end;
    assign inc   = {{RES_W{1'b0}}, !query_mode};

    always_comb begin
        in_count_a  = in_count_reg;
        out_count_a = out_count_reg;
        in_low_a    = in_low_reg;
        in_high_a   = in_high_reg;
        out_low_a   = out_low_reg;
        out_high_a  = out_high_reg;
        gsize_a     = gsize_reg;
        gis_in_a    = gis_in_reg;
        if (has) begin
            if (gsize_reg == '0) begin
                gis_in_a = is_in;
            end
            if (gsize_reg != {GSZ_W{1'b1}}) begin
                gsize_a = gsize_reg + GSZ_W'(1);
            end
            if (!seen) begin
                if (is_in) begin
                    in_count_a = in_count_reg + GSZ_W'(1);
                end else begin
                    out_count_a = out_count_reg + GSZ_W'(1);
                end
            end
            if (is_in) begin
                if (item.label < in_low_reg)  in_low_a  = item.label;
                if (item.label > in_high_reg) in_high_a = item.label;
            end else begin
                if (item.label < out_low_reg)  out_low_a  = item.label;
                if (item.label > out_high_reg) out_high_a = item.label;
            end
        end
        in_gmax_b  = in_gmax_reg;
        out_gmax_b = out_gmax_reg;
        if (close) begin
            if (gis_in_a) begin
                if (gsize_a > in_gmax_reg) in_gmax_b = gsize_a;
            end else begin
                if (gsize_a > out_gmax_reg) out_gmax_b = gsize_a;
            end
        end
    end

    always_comb begin
        if (in_count_a != '0) begin
            r[SYN_IN_MAX_GROUP] = {1'b0, in_gmax_b} + inc;
            r[SYN_IN_DISTINCT]  = {1'b0, in_count_a} + (RES_W+1)'(1);
            r[SYN_IN_MAX_LABEL] = (RES_W+1)'(in_high_a) + inc;
            r[SYN_IN_MIN_LABEL] = (RES_W+1)'(in_low_a) + inc;
        end else begin
            r[SYN_IN_MAX_GROUP] = (RES_W+1)'(1);
            r[SYN_IN_DISTINCT]  = (RES_W+1)'(1);
            r[SYN_IN_MAX_LABEL] = (RES_W+1)'(1);
            r[SYN_IN_MIN_LABEL] = (RES_W+1)'(num_pred) + (RES_W+1)'(query_mode);
        end
        if (out_count_a != '0) begin
            r[SYN_OUT_DISTINCT]  = {1'b0, out_count_a} + (RES_W+1)'(1);
            r[SYN_OUT_MAX_LABEL] = (RES_W+1)'(out_high_a) + inc;
            r[SYN_OUT_MIN_LABEL] = (RES_W+1)'(out_low_a) + inc;
            r[SYN_OUT_MAX_GROUP] = {1'b0, out_gmax_b} + inc;
        end else begin
            r[SYN_OUT_DISTINCT]  = (RES_W+1)'(1);
            r[SYN_OUT_MAX_LABEL] = (RES_W+1)'(1);
            r[SYN_OUT_MIN_LABEL] = {1'b0, num_pred, 1'b0} + (RES_W+1)'(query_mode);
            r[SYN_OUT_MAX_GROUP] = (RES_W+1)'(1);
        end
        for (int i = 0; i < SYN_COUNT; i++) begin
            res[i] = sat(r[i]);
        end
    end

    always_comb begin
        if (item.signature_end) begin
            in_count_next  = '0;
            out_count_next = '0;
            in_low_next    = {LABEL_W{1'b1}};
            in_high_next   = '0;
            out_low_next   = {LABEL_W{1'b1}};
            out_high_next  = '0;
            gsize_next     = '0;
            gis_in_next    = 1'b0;
            in_gmax_next   = '0;
            out_gmax_next  = '0;
        end else begin
            in_count_next  = in_count_a;
            out_count_next = out_count_a;
            in_low_next    = in_low_a;
            in_high_next   = in_high_a;
            out_low_next   = out_low_a;
            out_high_next  = out_high_a;
            gsize_next     = close ? '0 : gsize_a;
            gis_in_next    = gis_in_a;
            in_gmax_next   = in_gmax_b;
            out_gmax_next  = out_gmax_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
            in_low_reg    <= {LABEL_W{1'b1}};
            in_high_reg   <= '0;
            out_low_reg   <= {LABEL_W{1'b1}};
            out_high_reg  <= '0;
            gsize_reg     <= '0;
            gis_in_reg    <= 1'b0;
            in_gmax_reg   <= '0;
            out_gmax_reg  <= '0;
        end else if (fire) begin
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            in_low_reg    <= in_low_next;
            in_high_reg   <= in_high_next;
            out_low_reg   <= out_low_next;
            out_high_reg  <= out_high_next;
            gsize_reg     <= gsize_next;
            gis_in_reg    <= gis_in_next;
            in_gmax_reg   <= in_gmax_next;
            out_gmax_reg  <= out_gmax_next;
        end
    end

endmodule

// ===== rtl/edge_label_synopsis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_label_synopsis
// Eight-value synopsis of a vertex's edge-label signature, streamed one
// label per beat; one result beat per signature.
// The last beat passes the label stage p1, and the result beat is then
// registered once the output is free. Throughput: 1 beat per cycle while
// s_tready is high, set by one read and at most one write of the seen
// bitmap memory per beat. Reset: clears all control state, then sweeps
// all LABEL_SPACE bitmap entries with s_tready low; the sweep repeats
// after every 2**EPOCH_W - 1 signatures, preceded by an s_tready stall.
// ----------------------------------------------------------------------------
module edge_label_synopsis import els_pkg::*; #(
    parameter int LABEL_SPACE = LABEL_SPACE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // label[10:0], group_end[11], zero[15:12]
    input  logic                  s_tlast,   // signature_end
    input  logic                  s_tuser,   // no_label

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata    // in_max_group, in_distinct, in_max_label,
                                             // in_min_label, out_distinct, out_max_label,
                                             // out_min_label, out_max_group; 12 bits each
);

    logic [NP_W-1:0] num_pred_reg;
    logic            query_mode_reg;

    lbl_item_t       p1_reg;
    logic            p1_valid_reg;
    logic            m_valid_reg;
    syn_vec_t        m_res_reg;

    lbl_item_t       s_item;
    logic            s_fire;
    logic            out_free;
    logic            p1_fire;
    logic            p1_adv;
    logic            seen;
    logic            seen_busy;
    logic            last_epoch;
    seen_upd_t       upd;
    syn_vec_t        res;

    assign s_item.label         = s_tdata[LABEL_W-1:0];
    assign s_item.group_end     = s_tdata[LABEL_W];
    assign s_item.signature_end = s_tlast;
    assign s_item.no_label      = s_tuser;

    assign out_free = !m_valid_reg || m_tready;
    assign p1_fire  = p1_valid_reg && (!p1_reg.signature_end || out_free);
    assign p1_adv   = !p1_valid_reg || p1_fire;
    assign s_tready = !seen_busy && p1_adv
                      && !(p1_valid_reg && p1_reg.signature_end && last_epoch);
    assign s_fire   = s_tvalid && s_tready;

    assign upd.fire    = p1_fire;
    assign upd.mark    = !p1_reg.no_label;
    assign upd.sig_end = p1_reg.signature_end;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_pred_reg   <= NP_W'(1);
            query_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NUM_PRED:   num_pred_reg   <= cfg_wr_data[NP_W-1:0];
                REG_QUERY_MODE: query_mode_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // advance the label stage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            p1_valid_reg <= s_fire;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (p1_fire && p1_reg.signature_end) begin
            m_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_fire && p1_reg.signature_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    els_seen #(
        .LABEL_SPACE (LABEL_SPACE)
    ) u_seen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (s_fire),
        .rd_label   (s_item.label),
        .upd        (upd),
        .seen       (seen),
        .busy       (seen_busy),
        .last_epoch (last_epoch)
    );

    els_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (p1_fire),
        .item       (p1_reg),
        .seen       (seen),
        .num_pred   (num_pred_reg),
        .query_mode (query_mode_reg),
        .res        (res)
    );

endmodule
